@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define VFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ rtl/core/vfd_pkg.sv @@
// Shared types, widths and helpers for the VADPCM frame decoder.
// No dependencies; used by vfd_mac and vadpcm_frame_decoder.
`timescale 1ns / 1ps

package vfd_pkg;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_SET   = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	localparam int SAMPLE_W = 16;
	localparam int RES_W    = 19;  // nibble << 15 at most
	localparam int PROD_W   = SAMPLE_W + RES_W;
	localparam int ACC_W    = 40;  // nine products of 2^33 fit
	localparam int SHIFT    = 11;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	function automatic logic signed [RES_W-1:0] scale_res(input logic [3:0] nib,
		input logic [3:0] scale);
		logic signed [RES_W-1:0] ext;
		ext = {{(RES_W-4){nib[3]}}, nib};
		return ext <<< scale;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(32767);
		lo = -ACC_W'(32768);
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

@@ rtl/core/vadpcm_frame_decoder.sv @@
// After the ninth frame byte is accepted, each sample's terms are issued in turn through the
// single codebook read port feeding one shared MAC, then drained, then offered once the output is free.
// No new frame byte is accepted while a frame decodes: s_tready is high only while idle.
// Load, history and header/residual bytes take one cycle each while idle.
// Reset (arst_n low): control, frame state and history clear; the codebook is not cleared.
// Depends on vfd_pkg and vfd_mac.
`timescale 1ns / 1ps

module vadpcm_frame_decoder #(
	parameter int CODEBOOK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] data_byte, [15:8] entry_index, [31:16] entry_value, [47:32] older_sample
	input  logic [47:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] sample
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// frame and history state
	logic [3:0]         pos_q;
	logic [3:0]         scale_q;
	logic [3:0]         pred_q;
	logic [3:0]         nib_q [16];
	logic signed [15:0] newest_q;
	logic signed [15:0] second_q;
	logic signed [15:0] hold6_q;   // sample 6 of the current half

	// sequencer: half, sample within half, term within sample
	logic       half_q;
	logic [2:0] j_q;
	logic [3:0] t_q;

	// input item fields
	vfd_pkg::mode_t     mode;
	logic [7:0]         data_byte;
	logic [7:0]         entry_index;
	logic signed [15:0] entry_value;
	logic signed [15:0] older_sample;
	logic               accept;

	assign mode         = vfd_pkg::mode_t'(s_tuser);
	assign data_byte    = s_tdata[7:0];
	assign entry_index  = s_tdata[15:8];
	assign entry_value  = s_tdata[31:16];
	assign older_sample = s_tdata[47:32];
	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;

	// term issue: t=0 row0[j]*l2, t=1 row1[j]*l1, t>=2 row1[j-k-1]*res[k], k=t-2
	logic [3:0]                        tap;
	logic [2:0]                        k_c;
	logic signed [vfd_pkg::RES_W-1:0]  operand;
	logic                              term_last;
	vfd_pkg::mac_ctl_t                 ctl;

	assign k_c       = 3'(t_q - 4'd2);
	assign term_last = (t_q == ({1'b0, j_q} + 4'd1));

	always_comb begin
		case (t_q)
			4'd0: begin
				tap     = {1'b0, j_q};
				operand = vfd_pkg::RES_W'(second_q);
			end
			4'd1: begin
				tap     = {1'b1, j_q};
				operand = vfd_pkg::RES_W'(newest_q);
			end
			default: begin
				tap     = 4'(5'd9 + {2'b00, j_q} - {1'b0, t_q});
				operand = vfd_pkg::scale_res(nib_q[{half_q, k_c}], scale_q);
			end
		endcase
	end

	assign ctl = '{valid: (state_q == ST_ISSUE), first: (t_q == 4'd0), last: term_last};

	logic signed [vfd_pkg::ACC_W-1:0] acc_q;
	logic                             done_q;

	vfd_mac #(
		.CODEBOOK_DEPTH(CODEBOOK_DEPTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (mode == vfd_pkg::MODE_LOAD)),
		.wr_idx  (entry_index),
		.wr_data (entry_value),
		.ctl     (ctl),
		.rd_idx  ({pred_q, tap}),
		.operand (operand),
		.acc_q   (acc_q),
		.done_q  (done_q)
	);

	// finish: floor shift, add own residual, saturate
	logic signed [vfd_pkg::RES_W-1:0] res_cur;
	logic signed [vfd_pkg::ACC_W-1:0] sum_c;
	logic signed [15:0]               sample_c;
	logic                             out_free;
	logic                             emit_c;
	logic [2:0]                       p_c;

	assign res_cur  = vfd_pkg::scale_res(nib_q[{half_q, j_q}], scale_q);
	assign sum_c    = (acc_q >>> vfd_pkg::SHIFT) + vfd_pkg::ACC_W'(res_cur);
	assign sample_c = vfd_pkg::sat16(sum_c);
	assign out_free = !m_tvalid || m_tready;
	assign emit_c   = (state_q == ST_EMIT) && out_free;
	assign p_c      = 3'(pos_q - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			scale_q  <= '0;
			pred_q   <= '0;
			for (int i = 0; i < 16; i++) begin
				nib_q[i] <= '0;
			end
			newest_q <= '0;
			second_q <= '0;
			hold6_q  <= '0;
			half_q   <= 1'b0;
			j_q      <= '0;
			t_q      <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			// a new sample loaded this cycle keeps valid high
			if (m_tvalid && m_tready && !emit_c) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							vfd_pkg::MODE_SET: begin
								newest_q <= entry_value;
								second_q <= older_sample;
							end
							vfd_pkg::MODE_CLEAR: begin
								newest_q <= '0;
								second_q <= '0;
							end
							vfd_pkg::MODE_BYTE: begin
								if (pos_q == 4'd0) begin
									scale_q <= data_byte[7:4];
									pred_q  <= data_byte[3:0];
									pos_q   <= 4'd1;
								end else begin
									nib_q[{p_c, 1'b0}] <= data_byte[7:4];
									nib_q[{p_c, 1'b1}] <= data_byte[3:0];
									if (pos_q == 4'd8) begin
										pos_q   <= '0;
										half_q  <= 1'b0;
										j_q     <= '0;
										t_q     <= '0;
										state_q <= ST_ISSUE;
									end else begin
										pos_q <= pos_q + 4'd1;
									end
								end
							end
							default: begin
								// codebook load is written by the MAC unit
							end
						endcase
					end
				end
				ST_ISSUE: begin
					if (term_last) begin
						state_q <= ST_DRAIN;
					end else begin
						t_q <= t_q + 4'd1;
					end
				end
				ST_DRAIN: begin
					if (done_q) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= sample_c;
						m_tlast  <= half_q && (j_q == 3'd7);
						t_q      <= '0;
						if (j_q == 3'd6) begin
							hold6_q <= sample_c;
						end
						if (j_q == 3'd7) begin
							// history for the next half or frame
							second_q <= hold6_q;
							newest_q <= sample_c;
							j_q      <= '0;
							if (half_q) begin
								state_q <= ST_IDLE;
							end else begin
								half_q  <= 1'b1;
								state_q <= ST_ISSUE;
							end
						end else begin
							j_q     <= j_q + 3'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/vfd_mac.sv @@
// Codebook memory and shared multiply-accumulate unit.
// Depends on vfd_pkg.
`timescale 1ns / 1ps

module vfd_mac #(
	parameter int CODEBOOK_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [7:0]                           wr_idx,
	input  logic signed [vfd_pkg::SAMPLE_W-1:0]  wr_data,
	input  vfd_pkg::mac_ctl_t                    ctl,
	input  logic [7:0]                           rd_idx,
	input  logic signed [vfd_pkg::RES_W-1:0]     operand,
	output logic signed [vfd_pkg::ACC_W-1:0]     acc_q,
	output logic                                 done_q
);

	localparam int AW = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;
	// one bit above the index so the depth itself is representable in the compare
	localparam int IW = ((AW > 8) ? AW : 8) + 1;

	logic signed [vfd_pkg::SAMPLE_W-1:0] mem [CODEBOOK_DEPTH];

	logic [IW-1:0] wr_ext;
	logic [IW-1:0] rd_ext;
	logic          wr_ok;
	logic          rd_ok;

	assign wr_ext = IW'(wr_idx);
	assign rd_ext = IW'(rd_idx);
	assign wr_ok  = wr_ext < IW'(CODEBOOK_DEPTH);
	assign rd_ok  = rd_ext < IW'(CODEBOOK_DEPTH);

	logic signed [vfd_pkg::SAMPLE_W-1:0] word_s1;
	logic signed [vfd_pkg::RES_W-1:0]    op_s1;
	logic                                ok_s1;
	vfd_pkg::mac_ctl_t                   ctl_s1;
	logic signed [vfd_pkg::PROD_W-1:0]   prod_s2;
	vfd_pkg::mac_ctl_t                   ctl_s2;

	logic signed [vfd_pkg::SAMPLE_W-1:0] word_eff;
	logic signed [vfd_pkg::PROD_W-1:0]   prod_c;

	// out-of-range codebook reads count as zero
	assign word_eff = ok_s1 ? word_s1 : '0;
	assign prod_c   = word_eff * op_s1;

	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			mem[wr_ext[AW-1:0]] <= wr_data;
		end
		word_s1 <= mem[rd_ext[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		op_s1   <= operand;
		ok_s1   <= rd_ok;
		prod_s2 <= prod_c;
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= vfd_pkg::ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + vfd_pkg::ACC_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid & ctl_s2.last;
		end
	end

endmodule

@@ rtl/core/vfd_checker.sv @@
// Port-level checker for the VADPCM frame decoder, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result holds
	`VFD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// mid-frame samples are shown only while the decoder is busy
	`VFD_ASSERT_NOW(a_busy_midframe, clk, arst_n, m_tvalid && !m_tlast, !s_tready)

	// a shown result carries known bits
	`VFD_ASSERT_NOW(a_out_known, clk, arst_n, m_tvalid, !$isunknown(m_tdata) && !$isunknown(m_tlast))

endmodule

bind vadpcm_frame_decoder vfd_checker u_vfd_checker (.*);
